// ===== rtl/rhe_pkg.sv =====
package rhe_pkg;

	localparam int MAX_PIXELS_LOG2 = 22;
	localparam int BINS = 256;
	localparam int BIN_W = 8;
	localparam int PCOUNT_W = 23;

	localparam logic [1:0] FUNC_COUNT = 2'd0;
	localparam logic [1:0] FUNC_BUILD = 2'd1;
	localparam logic [1:0] FUNC_MAP   = 2'd2;
	localparam logic [1:0] FUNC_CLEAR = 2'd3;

	localparam logic REG_PIXEL_COUNT = 1'b0;
	localparam logic REG_GRAY_OUTPUT = 1'b1;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
	} out_beat_t;

	// handshake between the top level and the divider
	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;

endpackage

// ===== rtl/rhe_div.sv =====
// Restoring divider, one quotient bit per cycle. Quotient saturates at 255.
module rhe_div #(
	parameter int NUM_W = 40,
	parameter int DEN_W = 23
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic             done,
	output logic [7:0]       quo
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;

	assign trial = {rem_q[DEN_W-1:0], num_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};

	// one shift-subtract step a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			if (!diff[DEN_W]) begin
				rem_q <= diff;
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = (quo_q > NUM_W'(255)) ? 8'd255 : quo_q[7:0];

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy_q)) else $error("done without busy");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("start while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");
endmodule

// ===== rtl/rgb_histogram_equalizer_core.sv =====
// Per-channel histogram equalizer for 8-bit RGB pixels. One item is taken at a time, and
// in_stall stays high from acceptance until that item's work is done. Count (func 0) and
// map (func 2) each pass through the idle state, then for each of the three channels a
// registered memory read followed by a write-back for count or a capture for map. A map
// result sits in an output register. A later map waits in its last step only while that
// register is still held. Build (func 1) walks all 768 bins. Each bin takes a read, a
// divider start, a bit-serial division and a table write. Clear (func 3) sweeps the 768
// histogram counters, one per cycle. After reset, a pass clears both the histograms and
// the tables, and no pixel is taken during it. Counters saturate at
// 2^(MAX_PIXELS_LOG2+1)-1. A pixel_count of 0 divides as 1.
module rgb_histogram_equalizer_core #(
	parameter int MAX_PIXELS_LOG2 = rhe_pkg::MAX_PIXELS_LOG2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  rhe_pkg::in_beat_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output rhe_pkg::out_beat_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [rhe_pkg::PCOUNT_W-1:0] cfg_data
);
	localparam int CNT_W = MAX_PIXELS_LOG2 + 1;
	localparam int CUM_W = CNT_W + 8;        // sum of 256 saturated counters
	localparam int NUM_W = CUM_W + 8;        // times 255
	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam int ADR_W = 10;
	localparam logic [ADR_W-1:0] LAST_ADR = ADR_W'(3 * rhe_pkg::BINS - 1);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_CNT_RD, S_CNT_WR, S_MAP_RD, S_MAP_OUT,
		S_BLD_RD, S_BLD_DIV, S_BLD_WAIT
	} state_t;

	state_t state_q;
	logic [rhe_pkg::PCOUNT_W-1:0] pixel_count_q;
	logic gray_q;
	logic boot_q;

	logic [CNT_W-1:0] hist_mem [3*rhe_pkg::BINS];
	logic [7:0]       tbl_mem  [3*rhe_pkg::BINS];

	logic [ADR_W-1:0] adr_q;
	logic [1:0]       ch_q;
	logic [7:0]       r_q, g_q, b_q;
	logic [CUM_W-1:0] cum_q;
	logic             out_valid_q;
	rhe_pkg::out_beat_t out_q;

	logic             h_we;
	logic [ADR_W-1:0] h_wadr;
	logic [CNT_W-1:0] h_wdat;
	logic [ADR_W-1:0] h_radr;
	logic [CNT_W-1:0] h_rdat;
	logic             t_we;
	logic [7:0]       t_wdat;
	logic [ADR_W-1:0] t_radr;
	logic [7:0]       t_rdat;
	logic [7:0]       tr_q, tg_q;

	rhe_pkg::div_ctl_t dctl;
	logic [NUM_W-1:0] div_num;
	logic [rhe_pkg::PCOUNT_W-1:0] div_den;
	logic [7:0] div_quo;
	logic [CUM_W-1:0] cum_nx;
	logic in_acc;
	logic map_emit;

	assign in_acc    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// last map step may load the output register once it is free or being taken
	assign map_emit = (state_q == S_MAP_OUT) && (ch_q == 2'd3) &&
		(!out_valid_q || !out_stall);

	// addresses per channel
	function automatic logic [ADR_W-1:0] ch_adr(input logic [1:0] ch, input logic [7:0] v);
		ch_adr = {ch, v};
	endfunction

	// histogram memory port
	always_ff @(posedge clk) begin
		if (h_we)
			hist_mem[h_wadr] <= h_wdat;
		h_rdat <= hist_mem[h_radr];
	end

	always_ff @(posedge clk) begin
		if (t_we)
			tbl_mem[adr_q] <= t_wdat;
		t_rdat <= tbl_mem[t_radr];
	end

	assign cum_nx  = (adr_q[7:0] == 8'd0) ? CUM_W'(h_rdat) : cum_q + CUM_W'(h_rdat);
	assign div_num = NUM_W'({cum_nx, 8'd0}) - NUM_W'(cum_nx);
	assign div_den = (pixel_count_q == '0) ? rhe_pkg::PCOUNT_W'(1) : pixel_count_q;
	assign dctl.start = (state_q == S_BLD_DIV);
	// tables are written by the build, and zeroed by the pass after reset
	assign t_we   = dctl.done || (state_q == S_CLEAR && boot_q);
	assign t_wdat = (state_q == S_CLEAR) ? 8'd0 : div_quo;

	rhe_div #(.NUM_W(NUM_W), .DEN_W(rhe_pkg::PCOUNT_W)) u_div (
		.clk, .arst_n, .start(dctl.start), .num(div_num), .den(div_den),
		.busy(dctl.busy), .done(dctl.done), .quo(div_quo)
	);

	// memory address and write selection
	always_comb begin
		h_we   = 1'b0;
		h_wadr = adr_q;
		h_wdat = '0;
		h_radr = adr_q;
		t_radr = ch_adr(2'd0, r_q);
		unique case (state_q)
			S_CLEAR: h_we = 1'b1;
			S_CNT_RD: h_radr = ch_adr(ch_q, (ch_q == 2'd0) ? r_q :
				(ch_q == 2'd1) ? g_q : b_q);
			S_CNT_WR: begin
				h_we   = 1'b1;
				h_wadr = ch_adr(ch_q, (ch_q == 2'd0) ? r_q : (ch_q == 2'd1) ? g_q : b_q);
				h_wdat = (h_rdat == CNT_MAX) ? h_rdat : h_rdat + 1'b1;
			end
			S_MAP_RD: t_radr = ch_adr(ch_q, (ch_q == 2'd0) ? r_q :
				(ch_q == 2'd1) ? g_q : b_q);
			// keep the blue entry on the read port while the result waits
			S_MAP_OUT: t_radr = ch_adr(2'd2, b_q);
			default: ;
		endcase
	end

	// gray value of the mapped color
	logic [7:0] eb;
	logic [12:0] ysum;
	assign eb   = t_rdat;
	assign ysum = 13'(tr_q) * 13'd11 + 13'({tg_q, 4'd0}) + 13'(eb) * 13'd5;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			boot_q        <= 1'b1;
			adr_q         <= '0;
			ch_q          <= '0;
			pixel_count_q <= rhe_pkg::PCOUNT_W'(65536);
			gray_q        <= 1'b0;
			out_valid_q   <= 1'b0;
			out_q         <= '0;
			cum_q         <= '0;
			tr_q          <= '0;
			tg_q          <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == rhe_pkg::REG_PIXEL_COUNT)
					pixel_count_q <= cfg_data;
				else
					gray_q <= cfg_data[0];
			end
			if (map_emit)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					if (adr_q == LAST_ADR) begin
						adr_q   <= '0;
						boot_q  <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						adr_q <= adr_q + 1'b1;
					end
				end
				S_IDLE: begin
					ch_q  <= '0;
					adr_q <= '0;
					if (in_acc) begin
						unique case (in_data.func)
							rhe_pkg::FUNC_COUNT: state_q <= S_CNT_RD;
							rhe_pkg::FUNC_BUILD: state_q <= S_BLD_RD;
							rhe_pkg::FUNC_MAP:   state_q <= S_MAP_RD;
							rhe_pkg::FUNC_CLEAR: state_q <= S_CLEAR;
							default: ;
						endcase
					end
				end
				S_CNT_RD: state_q <= S_CNT_WR;
				S_CNT_WR: begin
					ch_q    <= ch_q + 1'b1;
					state_q <= (ch_q == 2'd2) ? S_IDLE : S_CNT_RD;
				end
				S_MAP_RD: begin
					ch_q    <= ch_q + 1'b1;
					state_q <= S_MAP_OUT;
				end
				S_MAP_OUT: begin
					if (ch_q == 2'd1) tr_q <= t_rdat;
					if (ch_q == 2'd2) tg_q <= t_rdat;
					if (ch_q == 2'd3) begin
						if (map_emit) begin
							if (gray_q)
								out_q <= '{ysum[12:5], ysum[12:5], ysum[12:5]};
							else
								out_q <= '{tr_q, tg_q, t_rdat};
							state_q <= S_IDLE;
						end
					end else begin
						state_q <= S_MAP_RD;
					end
				end
				S_BLD_RD: state_q <= S_BLD_DIV;
				S_BLD_DIV: begin
					cum_q   <= cum_nx;
					state_q <= S_BLD_WAIT;
				end
				S_BLD_WAIT: begin
					if (dctl.done) begin
						if (adr_q == LAST_ADR) begin
							state_q <= S_IDLE;
						end else begin
							adr_q   <= adr_q + 1'b1;
							state_q <= S_BLD_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// pixel registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			r_q <= in_data.in_red;
			g_q <= in_data.in_green;
			b_q <= in_data.in_blue;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result dropped");
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> state_q == S_IDLE) else $error("accept while busy");
	a_tbl_write_build: assert property (@(posedge clk) disable iff (!arst_n)
		t_we |-> state_q == S_BLD_WAIT || (state_q == S_CLEAR && boot_q))
		else $error("table write outside build");
	a_div_only_build: assert property (@(posedge clk) disable iff (!arst_n)
		dctl.busy |-> state_q == S_BLD_WAIT) else $error("divider busy outside build");
endmodule
